>>> rtl/core/icr_pkg.sv
// Shared constants, codes and control types for the complex response interpolator.
package icr_pkg;

  localparam int NODES  = 32;
  localparam int POINTS = 256;
  localparam int NODE_W = 5;
  localparam int IDX_W  = 8;
  localparam int CNT_W  = 9;
  localparam int ADDR_W = NODE_W + IDX_W;
  localparam int DEPTH  = NODES * POINTS;
  localparam int LIM_W  = 6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Read address sources of the point memories.
  localparam logic [1:0] RD_APPEND = 2'd0;
  localparam logic [1:0] RD_MID    = 2'd1;
  localparam logic [1:0] RD_PICK   = 2'd2;
  localparam logic [1:0] RD_NEXT   = 2'd3;

  typedef struct packed {
    logic       load;
    logic       do_clear;
    logic       ap_wr;
    logic       q_init;
    logic       q_node;
    logic       s_upd;
    logic       cap0;
    logic       cap1;
    logic       div_step;
    logic       mul;
    logic       lerp;
    logic       sq;
    logic       sum;
    logic       root;
    logic       emit;
    logic [1:0] rd_sel;
  } ctl_t;

  typedef struct packed {
    logic lim_zero;
    logic cnt_zero;
    logic s_done;
    logic single;
    logic div_done;
    logic root_done;
    logic more;
  } sts_t;

endpackage

>>> rtl/core/icr_ctrl.sv
// Controller state machine that sequences clear, append and query transactions.
module icr_ctrl
  import icr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] command,
  input  sts_t       sts,
  output logic       busy,
  output ctl_t       ctl
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_AP_RD = 5'd2;
  localparam logic [4:0] S_AP_WR = 5'd3;
  localparam logic [4:0] S_QINIT = 5'd4;
  localparam logic [4:0] S_QNODE = 5'd5;
  localparam logic [4:0] S_SCHK  = 5'd6;
  localparam logic [4:0] S_SUPD  = 5'd7;
  localparam logic [4:0] S_PICK  = 5'd8;
  localparam logic [4:0] S_CAP0  = 5'd9;
  localparam logic [4:0] S_CAP1  = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_MUL   = 5'd12;
  localparam logic [4:0] S_LERP  = 5'd13;
  localparam logic [4:0] S_SQ    = 5'd14;
  localparam logic [4:0] S_SUM   = 5'd15;
  localparam logic [4:0] S_ROOT  = 5'd16;
  localparam logic [4:0] S_EMIT  = 5'd17;

  logic [4:0] state, state_next;

  assign busy = (state != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.rd_sel = RD_MID;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (command)
            CMD_CLEAR:  state_next = S_CLR;
            CMD_APPEND: state_next = S_AP_RD;
            CMD_QUERY:  state_next = S_QINIT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        ctl.do_clear = 1'b1;
        state_next   = S_IDLE;
      end
      S_AP_RD: begin
        ctl.rd_sel = RD_APPEND;
        state_next = S_AP_WR;
      end
      S_AP_WR: begin
        ctl.ap_wr  = 1'b1;
        state_next = S_IDLE;
      end
      S_QINIT: begin
        ctl.q_init = 1'b1;
        state_next = sts.lim_zero ? S_IDLE : S_QNODE;
      end
      S_QNODE: begin
        ctl.q_node = 1'b1;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (sts.cnt_zero) begin
          state_next = S_EMIT;
        end else if (sts.s_done) begin
          state_next = S_PICK;
        end else begin
          ctl.rd_sel = RD_MID;
          state_next = S_SUPD;
        end
      end
      S_SUPD: begin
        ctl.s_upd  = 1'b1;
        state_next = S_SCHK;
      end
      S_PICK: begin
        ctl.rd_sel = RD_PICK;
        state_next = S_CAP0;
      end
      S_CAP0: begin
        ctl.cap0   = 1'b1;
        ctl.rd_sel = RD_NEXT;
        state_next = sts.single ? S_SQ : S_CAP1;
      end
      S_CAP1: begin
        ctl.cap1   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_LERP;
      end
      S_LERP: begin
        ctl.lerp   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        ctl.sq     = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        ctl.sum    = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        ctl.root = 1'b1;
        if (sts.root_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        ctl.emit   = 1'b1;
        state_next = sts.more ? S_QNODE : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // A new transaction is only taken when the controller is idle.
  assert property (@(posedge clk) disable iff (rst)
    ctl.load |-> (state == S_IDLE))
    else $error("load issued outside idle");

  // Division always runs its sixteen steps before the multiply.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> $past(sts.div_done))
    else $error("multiply before division finished");

  // A result is only emitted after a root or for an empty node.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ($past(sts.root_done) || sts.cnt_zero))
    else $error("emit without a finished root");

endmodule

>>> rtl/core/icr_dp.sv
// Datapath: point memories, counts, search, divider, interpolation and square root.
module icr_dp
  import icr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  output sts_t                 sts,
  input  logic [NODE_W-1:0]    node,
  input  logic [31:0]          frequency,
  input  logic signed [23:0]   amp_real,
  input  logic signed [23:0]   amp_imag,
  input  logic                 cfg_we,
  input  logic [LIM_W-1:0]     cfg_wdata,
  output logic                 strobe,
  output logic [NODE_W-1:0]    node_index,
  output logic signed [24:0]   signed_magnitude,
  output logic                 node_empty,
  output logic                 last
);

  // Point storage, one row of POINTS entries per node.
  logic [31:0] freq_mem [DEPTH];
  logic [47:0] amp_mem  [DEPTH];
  logic [CNT_W-1:0] pcount [NODES];

  logic [LIM_W-1:0]  nodes_in_use;
  logic [NODE_W-1:0] node_q;
  logic [31:0]       f_q;
  logic signed [23:0] re_in, im_in;

  logic [LIM_W-1:0]  lim, n;
  logic [CNT_W-1:0]  cnt, lo, hi;
  logic [31:0]       rd_freq;
  logic [47:0]       rd_amp;
  logic [ADDR_W-1:0] rd_addr, wr_addr;

  logic [31:0]        f0, dvs;
  logic signed [24:0] a_re, a_im, b_re, b_im, re, im;
  logic [32:0]        rem;
  logic [15:0]        k;
  logic [3:0]         div_cnt;
  logic signed [41:0] prod_re, prod_im;
  logic [49:0]        sq_re, sq_im;
  logic [49:0]        x, r, rbit;
  logic [4:0]         root_cnt;

  logic [CNT_W-1:0] mid, ap_cnt, pick_idx;
  logic             ap_ok;
  logic [32:0]      div_t;
  logic [49:0]      root_t;
  logic [LIM_W-1:0] lim_cfg, n_inc;
  logic signed [24:0] mag;

  assign mid      = CNT_W'((lo + hi) >> 1);
  assign ap_cnt   = pcount[node_q];
  assign pick_idx = (lo == '0) ? '0 : lo - CNT_W'(1);
  assign lim_cfg  = (nodes_in_use > LIM_W'(NODES)) ? LIM_W'(NODES) : nodes_in_use;
  assign n_inc    = n + LIM_W'(1);
  assign ap_ok    = (ap_cnt < CNT_W'(POINTS)) && ((ap_cnt == '0) || (f_q >= rd_freq));
  assign wr_addr  = {node_q, ap_cnt[IDX_W-1:0]};
  assign div_t    = {rem[31:0], 1'b0};
  assign root_t   = r + rbit;
  assign mag      = $signed({1'b0, r[23:0]});

  // Read address selection.
  always_comb begin
    case (ctl.rd_sel)
      RD_APPEND: rd_addr = {node_q, IDX_W'(ap_cnt - CNT_W'(1))};
      RD_MID:    rd_addr = {n[NODE_W-1:0], mid[IDX_W-1:0]};
      RD_PICK:   rd_addr = {n[NODE_W-1:0], pick_idx[IDX_W-1:0]};
      RD_NEXT:   rd_addr = {n[NODE_W-1:0], lo[IDX_W-1:0]};
      default:   rd_addr = '0;
    endcase
  end

  // Point memories with registered read data.
  always_ff @(posedge clk) begin
    rd_freq <= freq_mem[rd_addr];
    rd_amp  <= amp_mem[rd_addr];
    if (ctl.ap_wr && ap_ok) begin
      freq_mem[wr_addr] <= f_q;
      amp_mem[wr_addr]  <= {im_in, re_in};
    end
  end

  // Point counts and the node count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NODES; j++) begin
        pcount[j] <= '0;
      end
      nodes_in_use <= LIM_W'(32);
    end else begin
      if (cfg_we) begin
        nodes_in_use <= cfg_wdata;
      end
      if (ctl.do_clear) begin
        pcount[node_q] <= '0;
      end else if (ctl.ap_wr && ap_ok) begin
        pcount[node_q] <= ap_cnt + CNT_W'(1);
      end
    end
  end

  // Transaction capture and search bounds.
  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
      n  <= '0;
    end else begin
      if (ctl.q_init) begin
        n <= '0;
      end else if (ctl.emit) begin
        n <= n_inc;
      end
      if (ctl.q_node) begin
        lo <= '0;
        hi <= pcount[n[NODE_W-1:0]];
      end else if (ctl.s_upd) begin
        if (rd_freq <= f_q) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      node_q <= node;
      f_q    <= frequency;
      re_in  <= amp_real;
      im_in  <= amp_imag;
    end
    if (ctl.q_init) begin
      lim <= lim_cfg;
    end
    if (ctl.q_node) begin
      cnt <= pcount[n[NODE_W-1:0]];
    end
  end

  // Bracketing points, bit-serial fraction divider, multiply and interpolation.
  always_ff @(posedge clk) begin
    if (ctl.cap0) begin
      f0   <= rd_freq;
      a_re <= 25'(signed'(rd_amp[23:0]));
      a_im <= 25'(signed'(rd_amp[47:24]));
      re   <= 25'(signed'(rd_amp[23:0]));
      im   <= 25'(signed'(rd_amp[47:24]));
    end else if (ctl.lerp) begin
      re <= a_re + 25'((prod_re + 42'sd32768) >>> 16);
      im <= a_im + 25'((prod_im + 42'sd32768) >>> 16);
    end
    if (ctl.cap1) begin
      dvs     <= rd_freq - f0;
      rem     <= {1'b0, f_q - f0};
      b_re    <= 25'(signed'(rd_amp[23:0]));
      b_im    <= 25'(signed'(rd_amp[47:24]));
      div_cnt <= '0;
    end else if (ctl.div_step) begin
      div_cnt <= div_cnt + 4'd1;
      if (div_t >= {1'b0, dvs}) begin
        rem <= div_t - {1'b0, dvs};
        k   <= {k[14:0], 1'b1};
      end else begin
        rem <= div_t;
        k   <= {k[14:0], 1'b0};
      end
    end
    if (ctl.mul) begin
      prod_re <= (b_re - a_re) * $signed({1'b0, k});
      prod_im <= (b_im - a_im) * $signed({1'b0, k});
    end
  end

  // Squares and the bit-serial square root.
  always_ff @(posedge clk) begin
    if (ctl.sq) begin
      sq_re <= 50'(re * re);
      sq_im <= 50'(im * im);
    end
    if (ctl.sum) begin
      x        <= sq_re + sq_im;
      r        <= '0;
      rbit     <= 50'(1) << 48;
      root_cnt <= '0;
    end else if (ctl.root) begin
      root_cnt <= root_cnt + 5'd1;
      rbit     <= rbit >> 2;
      if (x >= root_t) begin
        x <= x - root_t;
        r <= (r >> 1) + rbit;
      end else begin
        r <= r >> 1;
      end
    end
  end

  // Result registers, valid for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      node_index <= n[NODE_W-1:0];
      node_empty <= (cnt == '0);
      last       <= (n_inc == lim);
      if (cnt == '0) begin
        signed_magnitude <= '0;
      end else begin
        signed_magnitude <= (im > 25'sd0) ? mag : -mag;
      end
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.lim_zero  = (lim_cfg == '0);
    sts.cnt_zero  = (cnt == '0);
    sts.s_done    = (lo == hi);
    sts.single    = (lo == '0) || (lo == cnt);
    sts.div_done  = (div_cnt == 4'd15);
    sts.root_done = (root_cnt == 5'd24);
    sts.more      = (n_inc < lim);
  end

  // The search window never inverts.
  assert property (@(posedge clk) disable iff (rst) lo <= hi)
    else $error("search bounds crossed");

  // The divisor is nonzero whenever the fraction is used.
  assert property (@(posedge clk) disable iff (rst) ctl.mul |-> (dvs != '0))
    else $error("interpolation with zero frequency span");

  // A result strobe always follows an emit command.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(ctl.emit))
    else $error("result without emit");

endmodule

>>> rtl/core/interpolate_complex_response.sv
// Top level of the per-node complex response interpolator.
// A clear or an append gives no result. A query gives one result per
// node in use, one strobe each, in node order; the receiver cannot stall and must take every
// strobed result. Per node, an empty node skips the search and the arithmetic, and a frequency
// outside the table skips the divider and the interpolation. The binary search makes at most
// 9 probes for 256 points. The pace is set by the single read port of the point memories,
// the 16-step fraction divider and the 25-step square root.
// busy is high for the whole transaction.
module interpolate_complex_response
  import icr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [NODE_W-1:0]          node,
  input  logic [31:0]                frequency,
  input  logic signed [23:0]         amp_real,
  input  logic signed [23:0]         amp_imag,
  input  logic                       cfg_we,
  input  logic [LIM_W-1:0]           cfg_wdata,
  output logic                       strobe,
  output logic [NODE_W-1:0]          node_index,
  output logic signed [24:0]         signed_magnitude,
  output logic                       node_empty,
  output logic                       last
);

  ctl_t ctl;
  sts_t sts;

  // Sequencer.
  icr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .busy    (busy),
    .ctl     (ctl)
  );

  // Storage and arithmetic.
  icr_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .node             (node),
    .frequency        (frequency),
    .amp_real         (amp_real),
    .amp_imag         (amp_imag),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .strobe           (strobe),
    .node_index       (node_index),
    .signed_magnitude (signed_magnitude),
    .node_empty       (node_empty),
    .last             (last)
  );

endmodule

>>> tb/interpolate_complex_response_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the complex response interpolator: directed table, then random traffic.
module interpolate_complex_response_tb
  import icr_pkg::*;
;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_ITEMS = 198;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [NODE_W-1:0]  nd;
    logic [31:0]        freq;
    logic signed [23:0] re;
    logic signed [23:0] im;
  } txn_t;

  typedef struct packed {
    logic [NODE_W-1:0]  idx;
    logic signed [24:0] mag;
    logic               empty;
    logic               last;
  } result_t;

  typedef struct {
    txn_t               t;
    bit                 typed;
    logic signed [24:0] mag;
    logic               empty;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = CMD_CLEAR;
  logic [NODE_W-1:0] node = '0;
  logic [31:0] frequency = '0;
  logic signed [23:0] amp_real = '0;
  logic signed [23:0] amp_imag = '0;
  logic cfg_we = 1'b0;
  logic [LIM_W-1:0] cfg_wdata = '0;
  logic strobe;
  logic [NODE_W-1:0] node_index;
  logic signed [24:0] signed_magnitude;
  logic node_empty;
  logic last;

  // Shadow copy of the response tables and the node count register.
  logic [31:0]        tbl_freq [NODES][POINTS];
  logic signed [23:0] tbl_re   [NODES][POINTS];
  logic signed [23:0] tbl_im   [NODES][POINTS];
  int                 tbl_count [NODES];
  int                 answered_nodes = 32;

  result_t pending_results[$];
  int      failures = 0;
  longint  cycles = 0;
  bit      quiet = 1'b0;
  row_t    directed[$];

  interpolate_complex_response DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .node(node), .frequency(frequency),
    .amp_real(amp_real), .amp_imag(amp_imag),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .strobe(strobe), .node_index(node_index), .signed_magnitude(signed_magnitude),
    .node_empty(node_empty), .last(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("interpolate_complex_response regression: fail");
      $finish;
    end
  end

  // Every strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: node_index %0d", node_index);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (node_index !== exp_r.idx) begin
          $error("node_index: expected %0d, got %0d", exp_r.idx, node_index);
          failures++;
        end
        if (signed_magnitude !== exp_r.mag) begin
          $error("signed_magnitude: expected %0d, got %0d", exp_r.mag, signed_magnitude);
          failures++;
        end
        if (node_empty !== exp_r.empty) begin
          $error("node_empty: expected %0d, got %0d", exp_r.empty, node_empty);
          failures++;
        end
        if (last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, last);
          failures++;
        end
      end
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // One part moved toward the next point by a 16-bit fraction, rounded half up.
  function automatic longint blend(longint a, longint b, longint k);
    return a + (((b - a) * k + 32768) >>> 16);
  endfunction

  function automatic logic signed [24:0] node_magnitude(int n, logic [31:0] f);
    int cnt = tbl_count[n];
    int i = 0;
    longint re, im, k, span, offs;
    longint unsigned mag;
    for (int j = 0; j < cnt; j++) if (tbl_freq[n][j] <= f) i = j + 1;
    if (i == 0) begin
      re = tbl_re[n][0];
      im = tbl_im[n][0];
    end else if (i == cnt) begin
      re = tbl_re[n][cnt-1];
      im = tbl_im[n][cnt-1];
    end else begin
      offs = {32'd0, f - tbl_freq[n][i-1]};
      span = {32'd0, tbl_freq[n][i] - tbl_freq[n][i-1]};
      k = (offs << 16) / span;
      if (k > 65535) k = 65535;
      re = blend(tbl_re[n][i-1], tbl_re[n][i], k);
      im = blend(tbl_im[n][i-1], tbl_im[n][i], k);
    end
    mag = int_sqrt(longint'(re * re) + longint'(im * im));
    return (im > 0) ? 25'(mag) : 25'(-longint'(mag));
  endfunction

  // Update the shadow tables and queue the results of one accepted transaction.
  // A typed value, when given, replaces the predicted result for node 0.
  function automatic void apply_txn(txn_t t, bit typed, logic signed [24:0] tmag, logic tempty);
    result_t r;
    int cnt;
    case (t.cmd)
      CMD_CLEAR: tbl_count[t.nd] = 0;
      CMD_APPEND: begin
        cnt = tbl_count[t.nd];
        if (cnt < POINTS && (cnt == 0 || t.freq >= tbl_freq[t.nd][cnt-1])) begin
          tbl_freq[t.nd][cnt] = t.freq;
          tbl_re[t.nd][cnt] = t.re;
          tbl_im[t.nd][cnt] = t.im;
          tbl_count[t.nd] = cnt + 1;
        end
      end
      CMD_QUERY: begin
        for (int n = 0; n < answered_nodes; n++) begin
          r.idx = n[NODE_W-1:0];
          r.empty = (tbl_count[n] == 0);
          r.mag = r.empty ? '0 : node_magnitude(n, t.freq);
          r.last = (n + 1 == answered_nodes);
          if (typed && n == 0) begin
            r.mag = tmag;
            r.empty = tempty;
          end
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Present one transaction and hold it until the block is idle again.
  task automatic send(txn_t t, bit typed = 1'b0, logic signed [24:0] tmag = '0,
                      logic tempty = 1'b0);
    start <= 1'b1;
    command <= t.cmd;
    node <= t.nd;
    frequency <= t.freq;
    amp_real <= t.re;
    amp_imag <= t.im;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_txn(t, typed, tmag, tempty);
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  // Drop start and let the block drain completely.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_nodes(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[LIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    answered_nodes = (v > NODES) ? NODES : v;
  endtask

  // Mostly ascending appends to a handful of nodes, with queries between points.
  function automatic txn_t random_txn();
    txn_t t;
    int sel = $urandom_range(0, 99);
    int n;
    logic [31:0] lo, hi;
    longint nf;
    t.re = 24'($urandom);
    t.im = 24'($urandom);
    t.nd = ($urandom_range(0, 9) < 7) ? NODE_W'($urandom_range(0, 7))
                                      : NODE_W'($urandom_range(0, 31));
    t.freq = $urandom;
    if (sel < 5) begin
      t.cmd = CMD_CLEAR;
    end else if (sel < 8) begin
      t.cmd = CMD_NONE;
    end else if (sel < 65) begin
      t.cmd = CMD_APPEND;
      n = tbl_count[t.nd];
      if (n > 0 && $urandom_range(0, 9) < 8) begin
        nf = longint'(tbl_freq[t.nd][n-1]) +
             (($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h1000_0000)
                                          : $urandom_range(0, 5000));
        t.freq = (nf > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nf[31:0];
      end else if (n == 0 && $urandom_range(0, 1) == 0) begin
        t.freq = $urandom_range(0, 100000);
      end
    end else begin
      t.cmd = CMD_QUERY;
      n = $urandom_range(0, 7);
      if (tbl_count[n] > 1 && $urandom_range(0, 9) < 7) begin
        lo = tbl_freq[n][0];
        hi = tbl_freq[n][tbl_count[n]-1];
        t.freq = lo + $urandom_range(0, hi - lo);
      end
    end
    return t;
  endfunction

  function automatic void add_row(logic [1:0] c, int n, logic [31:0] f, int re, int im,
                                  bit typed = 1'b0, int mag = 0, logic empty = 1'b0);
    row_t r;
    r.t = '{cmd: c, nd: n[NODE_W-1:0], freq: f, re: re[23:0], im: im[23:0]};
    r.typed = typed;
    r.mag = mag[24:0];
    r.empty = empty;
    directed.push_back(r);
  endfunction

  initial begin
    txn_t t;
    int   sizes[6] = '{0, 1, 63, 5, 32, 17};
    for (int n = 0; n < NODES; n++) tbl_count[n] = 0;

    // Directed rows: reset state, extremes, ordering rules and the ignored command.
    add_row(CMD_QUERY, 0, 32'd0, 0, 0, 1, 0, 1);
    add_row(CMD_NONE, 0, 32'd5, 1, 1);
    add_row(CMD_APPEND, 0, 32'd1000, 3, 4);
    add_row(CMD_QUERY, 0, 32'd0, 0, 0, 1, 5, 0);
    add_row(CMD_QUERY, 0, 32'hFFFF_FFFF, 0, 0, 1, 5, 0);
    add_row(CMD_APPEND, 0, 32'd999, 7, 7);
    add_row(CMD_APPEND, 0, 32'd1000, -3, -4);
    add_row(CMD_QUERY, 0, 32'd1000, 0, 0, 1, -5, 0);
    add_row(CMD_APPEND, 0, 32'd3000, 8388607, -8388608);
    add_row(CMD_QUERY, 0, 32'd2000, 0, 0);
    add_row(CMD_QUERY, 0, 32'd2999, 0, 0);
    add_row(CMD_APPEND, 1, 32'd0, -8388608, 8388607);
    add_row(CMD_APPEND, 1, 32'hFFFF_FFFF, 8388607, -8388608);
    add_row(CMD_QUERY, 0, 32'h8000_0000, 0, 0);
    add_row(CMD_QUERY, 0, 32'hFFFF_FFFE, 0, 0);
    add_row(CMD_CLEAR, 0, 32'd0, 0, 0);
    add_row(CMD_QUERY, 0, 32'd5, 0, 0, 1, 0, 1);
    add_row(CMD_APPEND, 0, 32'd0, 0, 0);
    add_row(CMD_QUERY, 0, 32'd0, 0, 0, 1, 0, 0);
    add_row(CMD_APPEND, 31, 32'd7, 0, 1);
    add_row(CMD_QUERY, 31, 32'd7, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send(directed[i].t, directed[i].typed, directed[i].mag, directed[i].empty);
      maybe_idle();
    end

    // Fill node 31 past its capacity; the extra append must be dropped.
    drain();
    for (int j = 0; j <= POINTS; j++) begin
      t = '{cmd: CMD_APPEND, nd: 5'd31, freq: 32'(j * 1000),
            re: 24'($urandom), im: 24'($urandom)};
      send(t);
    end
    t = '{cmd: CMD_QUERY, nd: 5'd0, freq: 32'd255500, re: '0, im: '0};
    send(t);
    t.freq = 32'hFFFF_FFFF;
    send(t);
    t = '{cmd: CMD_CLEAR, nd: 5'd31, freq: '0, re: '0, im: '0};
    send(t);

    // Random phases, each under its own node count.
    for (int p = 0; p < 6; p++) begin
      set_nodes(sizes[p]);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
        quiet = (p == 4);
        send(random_txn());
        if (p == 2 && i == 20) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending_results.size() != 0) @(posedge clk);
        end else begin
          maybe_idle();
        end
      end
    end

    drain();
    if (failures == 0) begin
      $display("interpolate_complex_response regression: pass");
    end else begin
      $display("interpolate_complex_response regression: fail");
    end
    $finish;
  end

endmodule
